/* design/metsu_pkg.sv */
// Shared types and match tables of the markup entity and tag simplifier.
`default_nettype none

package metsu_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned CONS_W = 5;

  localparam byte_t CHAR_AMP = "&";
  localparam byte_t CHAR_LT  = "<";
  localparam byte_t CHAR_GT  = ">";

  localparam int unsigned NUM_ENT    = 5;
  localparam int unsigned ENT_MAXLEN = 6;

  localparam byte_t ENT_TEXT [NUM_ENT][ENT_MAXLEN] = '{
    '{"&", "g", "t", ";", 8'h00, 8'h00},
    '{"&", "l", "t", ";", 8'h00, 8'h00},
    '{"&", "a", "m", "p", ";", 8'h00},
    '{"&", "q", "u", "o", "t", ";"},
    '{"&", "a", "p", "o", "s", ";"}
  };
  localparam int unsigned ENT_LEN [NUM_ENT] = '{4, 4, 5, 6, 6};
  localparam byte_t ENT_CHAR [NUM_ENT] = '{">", "<", "&", "\"", "'"};

  localparam int unsigned NUM_TAG    = 9;
  localparam int unsigned TAG_MAXLEN = 5;

  localparam byte_t TAG_TEXT [NUM_TAG][TAG_MAXLEN] = '{
    '{"b", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "r", 8'h00, 8'h00, 8'h00},
    '{"/", "t", "r", 8'h00, 8'h00},
    '{"k", "r", "e", "f", 8'h00},
    '{"/", "k", "r", "e", "f"},
    '{"e", "x", 8'h00, 8'h00, 8'h00},
    '{"/", "e", "x", 8'h00, 8'h00}
  };
  localparam int unsigned TAG_LEN [NUM_TAG] = '{1, 1, 1, 2, 3, 4, 5, 2, 3};
  localparam logic TAG_PASS [NUM_TAG] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                          1'b0, 1'b0};
  localparam byte_t TAG_CODE [NUM_TAG] = '{"<", "<", "<", "[", "]", "{", "}",
                                          "\\", "\\"};

  typedef struct packed {
    logic              decided;
    logic              has_emit;
    byte_t             emit;
    logic [CONS_W-1:0] consume;
  } dec_t;

endpackage

`default_nettype wire

/* design/markup_entity_tag_simplifier_unit.sv */
// Top level: entity decoder and tag rewriter over a byte stream.
// A byte decided on arrival is written to the window and then to the output register.
// Input is held while the window head is decided, so plain text alternates between taking
// and emitting a byte; the match unit decides again after each byte emitted or tag dropped.
// At end of message S_MARK sends the closing item; output stalls hold the sequencer.
// Reset clears the fill count, flags and sequencer; window bytes stay undefined until written.
`default_nettype none

module markup_entity_tag_simplifier_unit #(
  parameter int unsigned MAX_TAG_NAME = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  metsu_pkg::byte_t      s_axis_tdata_i,   // [7:0] in_byte
  input  logic                  s_axis_tlast_i,   // end_of_message
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output metsu_pkg::byte_t      m_axis_tdata_o,   // [7:0] out_byte
  output logic                  m_axis_tuser_o,   // [0] byte_valid
  output logic                  m_axis_tlast_o    // message_done
);

  import metsu_pkg::*;

  localparam int unsigned DEPTH  = MAX_TAG_NAME + 2;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_SCAN = 2'b01,
    S_MARK = 2'b10
  } state_e;

  state_e            state_q, state_d;
  byte_t             win_q [DEPTH];
  byte_t             win_shift [DEPTH];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              fin_q, fin_d;
  logic              pend_vld_q, pend_vld_d;
  byte_t             pend_byte_q, pend_byte_d;
  logic              out_vld_q;
  byte_t             out_byte_q;
  logic              out_bv_q;
  logic              out_last_q;

  dec_t              dec;
  logic              out_free;
  logic              accept;
  logic              step;
  logic              load_out;
  byte_t             ld_byte;
  logic              ld_bv;
  logic              ld_last;

  metsu_decide #(
    .MAX_TAG_NAME(MAX_TAG_NAME),
    .DEPTH       (DEPTH),
    .FILL_W      (FILL_W)
  ) u_decide (
    .win_i (win_q),
    .fill_i(fill_q),
    .fin_i (fin_q),
    .dec_o (dec)
  );

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_SCAN) && !fin_q &&
                           ((fill_q == '0) || !dec.decided);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    pend_vld_d  = pend_vld_q;
    pend_byte_d = pend_byte_q;
    step        = 1'b0;
    load_out    = 1'b0;
    ld_byte     = dec.emit;
    ld_bv       = 1'b1;
    ld_last     = 1'b0;
    unique case (state_q)
      S_SCAN: begin
        if (fill_q == '0) begin
          if (fin_q) state_d = S_MARK;
        end else if (dec.decided) begin
          if (!dec.has_emit) begin
            step = 1'b1;
          end else if (!fin_q) begin
            if (out_free) begin
              load_out = 1'b1;
              step     = 1'b1;
            end
          end else if (!pend_vld_q) begin
            pend_vld_d  = 1'b1;
            pend_byte_d = dec.emit;
            step        = 1'b1;
          end else if (out_free) begin
            load_out    = 1'b1;
            ld_byte     = pend_byte_q;
            pend_byte_d = dec.emit;
            step        = 1'b1;
          end
        end
        if (accept) fin_d = s_axis_tlast_i;
      end
      S_MARK: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_byte    = pend_vld_q ? pend_byte_q : '0;
          ld_bv      = pend_vld_q;
          ld_last    = 1'b1;
          pend_vld_d = 1'b0;
          fin_d      = 1'b0;
          state_d    = S_SCAN;
        end
      end
      default: state_d = S_SCAN;
    endcase
  end

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (step) begin
      fill_d = fill_q - FILL_W'(dec.consume);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      win_shift[i] = win_q[i];
      for (int c = 1; c < DEPTH - i; c++) begin
        if (dec.consume == CONS_W'(c)) win_shift[i] = win_q[i+c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_SCAN;
      fill_q     <= '0;
      fin_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      fin_q      <= fin_d;
      pend_vld_q <= pend_vld_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    if (load_out) begin
      out_byte_q <= ld_byte;
      out_bv_q   <= ld_bv;
      out_last_q <= ld_last;
    end
    if (accept) begin
      win_q[fill_q[IDX_W-1:0]] <= s_axis_tdata_i;
    end else if (step) begin
      for (int i = 0; i < DEPTH; i++) win_q[i] <= win_shift[i];
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_bv_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

/* design/metsu_decide.sv */
// Match unit: decides the head of the lookahead window in one pass.
`default_nettype none

module metsu_decide #(
  parameter int unsigned MAX_TAG_NAME = 10,
  parameter int unsigned DEPTH        = MAX_TAG_NAME + 2,
  parameter int unsigned FILL_W       = $clog2(DEPTH + 1)
) (
  input  metsu_pkg::byte_t  win_i [DEPTH],
  input  logic [FILL_W-1:0] fill_i,
  input  logic              fin_i,
  output metsu_pkg::dec_t   dec_o
);

  import metsu_pkg::*;

  logic              ent_hit;
  logic              ent_maybe;
  byte_t             ent_chr;
  logic [CONS_W-1:0] ent_len;
  logic              stop_found;
  logic              stop_past;
  logic              stop_gt;
  logic [CONS_W-1:0] stop_pos;
  logic              tag_hit;
  logic              tag_pass;
  byte_t             tag_chr;

  always_comb begin
    logic prefix;
    ent_hit   = 1'b0;
    ent_maybe = 1'b0;
    ent_chr   = '0;
    ent_len   = '0;
    for (int k = 0; k < NUM_ENT; k++) begin
      prefix = 1'b1;
      for (int i = 0; i < ENT_MAXLEN; i++) begin
        if (i < ENT_LEN[k] && i < fill_i && win_i[i] != ENT_TEXT[k][i]) prefix = 1'b0;
      end
      if (prefix) begin
        if (fill_i >= ENT_LEN[k]) begin
          if (!ent_hit) begin
            ent_hit = 1'b1;
            ent_chr = ENT_CHAR[k];
            ent_len = CONS_W'(ENT_LEN[k]);
          end
        end else begin
          ent_maybe = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stop_found = 1'b0;
    stop_past  = 1'b0;
    stop_gt    = 1'b0;
    stop_pos   = '0;
    for (int j = 1; j < DEPTH; j++) begin
      if (!stop_found && (j >= fill_i || win_i[j] == CHAR_GT || j > MAX_TAG_NAME)) begin
        stop_found = 1'b1;
        stop_pos   = CONS_W'(j);
        stop_past  = (j >= fill_i);
        stop_gt    = (j < fill_i) && (win_i[j] == CHAR_GT);
      end
    end
  end

  always_comb begin
    logic same;
    tag_hit  = 1'b0;
    tag_pass = 1'b0;
    tag_chr  = '0;
    for (int k = 0; k < NUM_TAG; k++) begin
      same = (stop_pos == CONS_W'(TAG_LEN[k] + 1));
      for (int i = 0; i < TAG_MAXLEN; i++) begin
        if (i < TAG_LEN[k] && win_i[i+1] != TAG_TEXT[k][i]) same = 1'b0;
      end
      if (same && !tag_hit) begin
        tag_hit  = 1'b1;
        tag_pass = TAG_PASS[k];
        tag_chr  = TAG_CODE[k];
      end
    end
  end

  always_comb begin
    dec_o.decided  = 1'b1;
    dec_o.has_emit = 1'b1;
    dec_o.emit     = win_i[0];
    dec_o.consume  = CONS_W'(1);
    if (win_i[0] == CHAR_AMP) begin
      if (ent_hit) begin
        dec_o.emit    = ent_chr;
        dec_o.consume = ent_len;
      end else if (ent_maybe && !fin_i) begin
        dec_o.decided = 1'b0;
      end
    end else if (win_i[0] == CHAR_LT) begin
      if (stop_past) begin
        dec_o.decided = fin_i;
      end else if (stop_gt && stop_pos >= CONS_W'(2)) begin
        dec_o.has_emit = 1'b0;
        dec_o.consume  = stop_pos + CONS_W'(1);
        if (tag_hit) begin
          dec_o.has_emit = 1'b1;
          dec_o.emit     = tag_chr;
          if (tag_pass) dec_o.consume = CONS_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* design/metsu_checker.sv */
// Port-level checker for the markup simplifier, bound to the top level.
`default_nettype none

module metsu_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid_i,
  input wire logic             s_axis_tready_o,
  input wire metsu_pkg::byte_t s_axis_tdata_i,
  input wire logic             s_axis_tlast_i,
  input wire logic             m_axis_tvalid_o,
  input wire logic             m_axis_tready_i,
  input wire metsu_pkg::byte_t m_axis_tdata_o,
  input wire logic             m_axis_tuser_o,
  input wire logic             m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("output transaction changed while stalled");

  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("bare item without message end");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 8'h00)
    else $error("bare item carries nonzero data");

  a_hold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken before message end was flushed");

endmodule

bind markup_entity_tag_simplifier_unit metsu_checker u_metsu_checker (.*);

`default_nettype wire
